// ===== src/hlcs_pkg.sv =====
package hlcs_pkg;

  // Widths of the register file and of the item fields.
  localparam int unsigned RegWidth   = 16;
  localparam int unsigned RegIdxWidth = 3;
  localparam int unsigned ValveWidth = 4;
  localparam int unsigned StepWidth  = 2;
  localparam int unsigned CycleWidth = 32;
  localparam int unsigned NumSteps   = 4;

  typedef logic [RegWidth-1:0]   reg_t;
  typedef logic [ValveWidth-1:0] valve_t;
  typedef logic [StepWidth-1:0]  step_t;
  typedef logic [CycleWidth-1:0] cycle_t;

  // Configuration register indexes.
  typedef enum logic [RegIdxWidth-1:0] {
    REG_PALLET_RAISE = 3'd0,
    REG_WHEEL_LOWER  = 3'd1,
    REG_PALLET_LOWER = 3'd2,
    REG_WHEEL_RAISE  = 3'd3,
    REG_REST         = 3'd4
  } reg_idx_e;

  // Register reset values.
  localparam reg_t PalletRaiseReset = 16'd400;
  localparam reg_t WheelLowerReset  = 16'd600;
  localparam reg_t PalletLowerReset = 16'd200;
  localparam reg_t WheelRaiseReset  = 16'd200;
  localparam reg_t RestReset        = 16'd2000;

  // Valve patterns; the first valve of each pattern is bit 3.
  localparam valve_t ValvesOff        = 4'h0;
  localparam valve_t ValvesWheelDown  = 4'hB;
  localparam valve_t ValvesWheelUp    = 4'h3;
  localparam valve_t ValvesPalletUp   = 4'hD;
  localparam valve_t ValvesPalletDown = 4'h5;

  // Auto steps in their running order.
  typedef enum logic [StepWidth-1:0] {
    STEP_PALLET_UP   = 2'd0,
    STEP_WHEEL_DOWN  = 2'd1,
    STEP_PALLET_DOWN = 2'd2,
    STEP_WHEEL_UP    = 2'd3
  } step_e;

  // Valve pattern that an auto step drives during its on-time.
  function automatic valve_t step_pattern(input step_t step);
    valve_t pat;
    case (step_e'(step))
      STEP_PALLET_UP:   pat = ValvesPalletUp;
      STEP_WHEEL_DOWN:  pat = ValvesWheelDown;
      STEP_PALLET_DOWN: pat = ValvesPalletDown;
      STEP_WHEEL_UP:    pat = ValvesWheelUp;
      default:          pat = ValvesOff;
    endcase
    return pat;
  endfunction

endpackage

// ===== src/hlcs_if.sv =====
// Poll channel: one item carries the five qualified switch levels.
interface hlcs_in_if;
  logic valid;
  logic ready;
  logic stop_all;
  logic auto_select;
  logic wheel_select;
  logic raise_button;
  logic lower_button;

  modport source (
    output valid, stop_all, auto_select, wheel_select, raise_button, lower_button,
    input  ready
  );
  modport sink (
    input  valid, stop_all, auto_select, wheel_select, raise_button, lower_button,
    output ready
  );
endinterface

// Result channel: one item carries the valve pattern and sequencer status.
interface hlcs_out_if
  import hlcs_pkg::*;
;
  logic   valid;
  logic   ready;
  valve_t valve_pattern;
  step_t  current_step;
  logic   resting;
  cycle_t cycles_done;

  modport source (
    output valid, valve_pattern, current_step, resting, cycles_done,
    input  ready
  );
  modport sink (
    input  valid, valve_pattern, current_step, resting, cycles_done,
    output ready
  );
endinterface

// ===== src/hydraulic_lift_cycle_sequencer.sv =====
// Hydraulic lift cycle sequencer. Every poll item yields exactly one result
// item in the cycle after it is accepted, and a new poll is taken in every cycle
// (one item per cycle sustained) as long as the result register is empty or
// is being emptied in the same cycle; the only stage is that result register.
// A stop poll turns all valves off and restarts at step 0 but keeps the cycle
// count. In manual mode raise wins over lower and wheel_select picks the
// actuator. In auto mode the four steps (pallet up, wheel down, pallet down,
// wheel up) each drive their pattern for their on-time in polls, then rest
// with all valves off for rest_polls + 1 polls; finishing step 3 counts a cycle.
// Configuration registers are written through cfg_we_i and take effect for
// the next accepted poll; indexes beyond the register list are ignored.
module hydraulic_lift_cycle_sequencer
  import hlcs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [RegIdxWidth-1:0] cfg_idx_i,
  input  logic [RegWidth-1:0]    cfg_data_i,
  hlcs_in_if.sink                in_i,
  hlcs_out_if.source             out_o
);

  // Configuration registers.
  reg_t on_time_q [NumSteps];
  reg_t rest_polls_q;

  // Sequencer state.
  step_t  step_q, step_d;
  logic   rest_phase_q, rest_phase_d;
  reg_t   drive_elapsed_q, drive_elapsed_d;
  reg_t   rest_elapsed_q, rest_elapsed_d;
  cycle_t cycle_q, cycle_d;

  // Result register.
  logic   out_valid_q;
  valve_t valve_q, valve_d;

  logic in_accept;
  logic drive_done;
  logic in_rest;
  reg_t rest_count;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_q[STEP_PALLET_UP]   <= PalletRaiseReset;
      on_time_q[STEP_WHEEL_DOWN]  <= WheelLowerReset;
      on_time_q[STEP_PALLET_DOWN] <= PalletLowerReset;
      on_time_q[STEP_WHEEL_UP]    <= WheelRaiseReset;
      rest_polls_q                <= RestReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PALLET_RAISE: on_time_q[STEP_PALLET_UP]   <= cfg_data_i;
        REG_WHEEL_LOWER:  on_time_q[STEP_WHEEL_DOWN]  <= cfg_data_i;
        REG_PALLET_LOWER: on_time_q[STEP_PALLET_DOWN] <= cfg_data_i;
        REG_WHEEL_RAISE:  on_time_q[STEP_WHEEL_UP]    <= cfg_data_i;
        REG_REST:         rest_polls_q                <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Auto timing: the drive ends when its count reaches the on-time, and a
  // rest that starts in the same poll begins counting from zero.
  assign drive_done = !rest_phase_q && (drive_elapsed_q >= on_time_q[step_q]);
  assign in_rest    = rest_phase_q || drive_done;
  assign rest_count = drive_done ? '0 : rest_elapsed_q;

  // Next state and result for one poll.
  always_comb begin
    step_d          = step_q;
    rest_phase_d    = rest_phase_q;
    drive_elapsed_d = drive_elapsed_q;
    rest_elapsed_d  = rest_elapsed_q;
    cycle_d         = cycle_q;
    valve_d         = ValvesOff;
    if (in_i.stop_all) begin
      step_d          = step_t'(STEP_PALLET_UP);
      rest_phase_d    = 1'b0;
      drive_elapsed_d = '0;
      rest_elapsed_d  = '0;
    end else if (in_i.auto_select) begin
      if (!in_rest) begin
        drive_elapsed_d = drive_elapsed_q + 1'b1;
        valve_d         = step_pattern(step_q);
      end else if (rest_count >= rest_polls_q) begin
        rest_phase_d    = 1'b0;
        drive_elapsed_d = '0;
        rest_elapsed_d  = '0;
        step_d          = step_q + 1'b1;
        if (step_e'(step_q) == STEP_WHEEL_UP) begin
          cycle_d = cycle_q + 1'b1;
        end
      end else begin
        rest_phase_d   = 1'b1;
        rest_elapsed_d = rest_count + 1'b1;
      end
    end else begin
      rest_phase_d    = 1'b0;
      drive_elapsed_d = '0;
      rest_elapsed_d  = '0;
      if (in_i.raise_button) begin
        valve_d = in_i.wheel_select ? ValvesWheelDown : ValvesPalletUp;
      end else if (in_i.lower_button) begin
        valve_d = in_i.wheel_select ? ValvesWheelUp : ValvesPalletDown;
      end
    end
  end

  // State update on each accepted poll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q          <= '0;
      rest_phase_q    <= 1'b0;
      drive_elapsed_q <= '0;
      rest_elapsed_q  <= '0;
      cycle_q         <= '0;
    end else if (in_accept) begin
      step_q          <= step_d;
      rest_phase_q    <= rest_phase_d;
      drive_elapsed_q <= drive_elapsed_d;
      rest_elapsed_q  <= rest_elapsed_d;
      cycle_q         <= cycle_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Result payload; status fields come straight from the updated state.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      valve_q <= valve_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.valve_pattern = valve_q;
  assign out_o.current_step  = step_q;
  assign out_o.resting       = rest_phase_q;
  assign out_o.cycles_done   = cycle_q;

  // No valve is open during a rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rest_phase_q |-> valve_q == ValvesOff)
    else $error("valves driven during rest");

  // A stop poll yields all valves off at step 0, not resting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.stop_all |=>
      valve_q == ValvesOff && step_q == '0 && !rest_phase_q)
    else $error("stop poll not honored");

  // The cycle count only moves by one, and only on an accepted poll.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cycle_q != $past(cycle_q) |->
      $past(in_accept) && cycle_q == $past(cycle_q) + 1'b1)
    else $error("cycle count jumped");

  // Polls are refused only while a result waits to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_valid_q && !out_o.ready)
    else $error("poll refused without backpressure");

  // A rest is never entered outside auto mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_i.auto_select |=> !rest_phase_q)
    else $error("rest outside auto mode");

endmodule
